[hw/rtl/i2cebm_pkg.sv]
// Package for the single-byte I2C EEPROM master: phase codes, request and
// result structures, configuration defaults and register indexes.
// No dependencies.
package i2cebm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START1 = 4'd1,
    PH_DEVW   = 4'd2,
    PH_ACK1   = 4'd3,
    PH_ADDR   = 4'd4,
    PH_ACK2   = 4'd5,
    PH_DATA   = 4'd6,
    PH_ACK3   = 4'd7,
    PH_STOP   = 4'd8,
    PH_START2 = 4'd9,
    PH_DEVR   = 4'd10,
    PH_ACK4   = 4'd11,
    PH_READ   = 4'd12,
    PH_NACK   = 4'd13
  } phase_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [7:0]  ack_timeout;
    logic [15:0] half_period;
  } cfg_t;

  typedef struct packed {
    logic       start_req;
    logic       operation;
    logic [7:0] mem_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_data;
    logic       ack_missing;
  } res_t;

  localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'h50;
  localparam logic [7:0]  ACK_TIMEOUT_RESET    = 8'd250;
  localparam logic [15:0] HALF_PERIOD_RESET    = 16'd100;

  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_ACK_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_HALF_PERIOD    = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  function automatic logic is_ack(phase_t p);
    return (p == PH_ACK1) || (p == PH_ACK2) || (p == PH_ACK3) || (p == PH_ACK4);
  endfunction

  function automatic logic is_send(phase_t p);
    return (p == PH_DEVW) || (p == PH_ADDR) || (p == PH_DATA) || (p == PH_DEVR);
  endfunction

  function automatic logic [4:0] seg_total(phase_t p);
    logic [4:0] n;
    if ((p == PH_START1) || (p == PH_START2) || (p == PH_STOP)) begin
      n = 5'd3;
    end else if (is_ack(p)) begin
      n = 5'd4;
    end else if (p == PH_NACK) begin
      n = 5'd2;
    end else begin
      n = 5'd16;
    end
    return n;
  endfunction

endpackage

[hw/rtl/i2c_eeprom_byte_master_core.sv]
// Single-byte I2C EEPROM master: one request is one timing tick of the
// pin sequencer. An accepted request is registered, then stepped into the result
// register. Throughput is one request per cycle unless stalled; one step per tick.
// Synchronous active-low reset: phase idle, result valid low, registers at
// their defaults (device 0x50, timeout 250, half period 100).
// Depends on i2cebm_pkg and i2cebm_seq.
module i2c_eeprom_byte_master_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_start_req,
  input  logic        in_operation,
  input  logic [7:0]  in_mem_addr,
  input  logic [7:0]  in_write_data,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_level,
  output logic        out_sda_level,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_rx_data,
  output logic        out_ack_missing,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2cebm_pkg::*;

  cfg_t cfg_r;
  req_t req_r;
  res_t res_r, step_res;
  logic req_valid_r;
  logic out_valid_r;
  logic step_en;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= DEVICE_ADDRESS_RESET;
      cfg_r.ack_timeout    <= ACK_TIMEOUT_RESET;
      cfg_r.half_period    <= HALF_PERIOD_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_DEVICE_ADDRESS: cfg_r.device_address <= pwdata[6:0];
        REG_ACK_TIMEOUT:    cfg_r.ack_timeout    <= pwdata[7:0];
        REG_HALF_PERIOD:    cfg_r.half_period    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEVICE_ADDRESS: prdata = {25'd0, cfg_r.device_address};
      REG_ACK_TIMEOUT:    prdata = {24'd0, cfg_r.ack_timeout};
      REG_HALF_PERIOD:    prdata = {16'd0, cfg_r.half_period};
      default:            prdata = '0;
    endcase
  end

  assign step_en  = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        req_valid_r <= in_valid;
      end
      if (step_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r.start_req  <= in_start_req;
      req_r.operation  <= in_operation;
      req_r.mem_addr   <= in_mem_addr;
      req_r.write_data <= in_write_data;
      req_r.sda_in     <= in_sda_in;
    end
    if (step_en) begin
      res_r <= step_res;
    end
  end

  i2cebm_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .cfg     (cfg_r),
    .req     (req_r),
    .res     (step_res)
  );

  assign out_valid       = out_valid_r;
  assign out_scl_level   = res_r.scl_level;
  assign out_sda_level   = res_r.sda_level;
  assign out_busy_res    = res_r.busy_res;
  assign out_done_res    = res_r.done_res;
  assign out_rx_data     = res_r.rx_data;
  assign out_ack_missing = res_r.ack_missing;

endmodule

[hw/rtl/i2cebm_seq.sv]
// Transaction sequencer of the I2C EEPROM master: phase state and counters,
// with the per-tick step logic that yields line levels and status.
// Depends on i2cebm_pkg.
module i2cebm_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  i2cebm_pkg::cfg_t  cfg,
  input  i2cebm_pkg::req_t  req,
  output i2cebm_pkg::res_t  res
);
  import i2cebm_pkg::*;

  phase_t      phase_r, phase_nxt, ph_cur;
  logic [3:0]  bit_count_r, bit_count_nxt, bc_cur;
  logic [7:0]  shift_byte_r, shift_byte_nxt, sb_cur, sb_step;
  logic [15:0] tick_count_r, tick_count_nxt, tc_cur, tc_inc;
  logic [7:0]  ack_wait_r, ack_wait_nxt, aw_cur, aw_inc;
  logic [16:0] held_request_r, held_request_nxt;
  logic [7:0]  received_r, received_nxt;
  logic        error_flag_r, error_flag_nxt;
  logic [4:0]  bc_inc;
  logic [7:0]  dev_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      bit_count_r    <= '0;
      shift_byte_r   <= '0;
      tick_count_r   <= '0;
      ack_wait_r     <= '0;
      held_request_r <= '0;
      received_r     <= '0;
      error_flag_r   <= 1'b0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      bit_count_r    <= bit_count_nxt;
      shift_byte_r   <= shift_byte_nxt;
      tick_count_r   <= tick_count_nxt;
      ack_wait_r     <= ack_wait_nxt;
      held_request_r <= held_request_nxt;
      received_r     <= received_nxt;
      error_flag_r   <= error_flag_nxt;
    end
  end

  assign dev_byte = {cfg.device_address, 1'b0};

  always_comb begin
    ph_cur           = phase_r;
    bc_cur           = bit_count_r;
    sb_cur           = shift_byte_r;
    tc_cur           = tick_count_r;
    aw_cur           = ack_wait_r;
    held_request_nxt = held_request_r;
    received_nxt     = received_r;
    error_flag_nxt   = error_flag_r;

    if (phase_r > PH_NACK) begin
      ph_cur = PH_IDLE;
      bc_cur = '0;
      sb_cur = '0;
      tc_cur = '0;
      aw_cur = '0;
    end
    if ((ph_cur == PH_IDLE) && req.start_req) begin
      held_request_nxt = {req.operation, req.mem_addr, req.write_data};
      error_flag_nxt   = 1'b0;
      ph_cur = PH_START1;
      bc_cur = '0;
      sb_cur = '0;
      tc_cur = '0;
      aw_cur = '0;
    end

    phase_nxt      = ph_cur;
    bit_count_nxt  = bc_cur;
    shift_byte_nxt = sb_cur;
    tick_count_nxt = tc_cur;
    ack_wait_nxt   = aw_cur;

    tc_inc  = tc_cur + 16'd1;
    bc_inc  = {1'b0, bc_cur} + 5'd1;
    aw_inc  = (aw_cur != 8'hFF) ? (aw_cur + 8'd1) : aw_cur;
    sb_step = sb_cur;
    if (bc_cur[0] && (ph_cur == PH_READ)) begin
      sb_step = {sb_cur[6:0], req.sda_in};
    end else if (bc_cur[0] && is_send(ph_cur)) begin
      sb_step = {sb_cur[6:0], 1'b0};
    end

    res.scl_level = 1'b1;
    res.sda_level = 1'b1;
    res.busy_res  = 1'b0;
    res.done_res  = 1'b0;

    if (ph_cur != PH_IDLE) begin
      res.busy_res = 1'b1;
      if ((ph_cur == PH_START1) || (ph_cur == PH_START2)) begin
        res.scl_level = (bc_cur != 4'd0);
        res.sda_level = (bc_cur != 4'd2);
      end else if (ph_cur == PH_STOP) begin
        res.scl_level = (bc_cur != 4'd0);
        res.sda_level = (bc_cur == 4'd2);
      end else if (is_send(ph_cur)) begin
        res.scl_level = bc_cur[0];
        res.sda_level = sb_cur[7];
      end else if (is_ack(ph_cur) || (ph_cur == PH_NACK)) begin
        res.scl_level = (bc_cur != 4'd0);
      end else if (ph_cur == PH_READ) begin
        res.scl_level = bc_cur[0];
      end

      if (is_ack(ph_cur) && (bc_cur == 4'd2)) begin
        if (!req.sda_in) begin
          bit_count_nxt  = 4'd3;
          tick_count_nxt = '0;
        end else begin
          ack_wait_nxt = aw_inc;
          if (aw_inc >= cfg.ack_timeout) begin
            error_flag_nxt = 1'b1;
            phase_nxt      = PH_STOP;
            bit_count_nxt  = '0;
            tick_count_nxt = '0;
            ack_wait_nxt   = '0;
            shift_byte_nxt = '0;
          end
        end
      end else if (tc_inc >= cfg.half_period) begin
        tick_count_nxt = '0;
        shift_byte_nxt = sb_step;
        bit_count_nxt  = bc_inc[3:0];
        if (bc_inc >= seg_total(ph_cur)) begin
          bit_count_nxt  = '0;
          ack_wait_nxt   = '0;
          shift_byte_nxt = '0;
          unique case (ph_cur)
            PH_START1: begin
              phase_nxt      = PH_DEVW;
              shift_byte_nxt = dev_byte;
            end
            PH_DEVW: phase_nxt = PH_ACK1;
            PH_ACK1: begin
              phase_nxt      = PH_ADDR;
              shift_byte_nxt = held_request_nxt[15:8];
            end
            PH_ADDR: phase_nxt = PH_ACK2;
            PH_ACK2: begin
              if (held_request_nxt[16] == OP_READ) begin
                phase_nxt = PH_START2;
              end else begin
                phase_nxt      = PH_DATA;
                shift_byte_nxt = held_request_nxt[7:0];
              end
            end
            PH_DATA: phase_nxt = PH_ACK3;
            PH_ACK3: phase_nxt = PH_STOP;
            PH_START2: begin
              phase_nxt      = PH_DEVR;
              shift_byte_nxt = {dev_byte[7:1], 1'b1};
            end
            PH_DEVR: phase_nxt = PH_ACK4;
            PH_ACK4: phase_nxt = PH_READ;
            PH_READ: begin
              received_nxt = sb_step;
              phase_nxt    = PH_NACK;
            end
            PH_NACK: phase_nxt = PH_STOP;
            PH_STOP: begin
              phase_nxt     = PH_IDLE;
              res.busy_res  = 1'b0;
              res.done_res  = 1'b1;
            end
            default: phase_nxt = PH_IDLE;
          endcase
        end
      end else begin
        tick_count_nxt = tc_inc;
      end
    end

    res.rx_data     = received_nxt;
    res.ack_missing = error_flag_nxt;
  end

endmodule

[hw/rtl/i2cebm_checker.sv]
// Port-level checks for the I2C EEPROM master, bound to the top level.
// Depends on i2c_eeprom_byte_master_core.
module i2cebm_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_scl_level,
  input logic out_sda_level,
  input logic out_busy_res,
  input logic out_done_res
);

  a_reset_clears_valid: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("finishing result still busy");

  a_idle_lines_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_scl_level && out_sda_level)
    else $error("lines not released while idle");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_done_res)
      && $stable(out_scl_level) && $stable(out_sda_level))
    else $error("stalled result changed");

endmodule

bind i2c_eeprom_byte_master_core i2cebm_checker u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_scl_level (out_scl_level),
  .out_sda_level (out_sda_level),
  .out_busy_res  (out_busy_res),
  .out_done_res  (out_done_res)
);
